### rtl/bounded_deque_with_search_remove_assert.svh
// Assertion macros for the bounded deque with search and remove.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_REMOVE_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_REMOVE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bdq_pkg.sv
// Shared types and constants for the bounded deque with search and remove.
package bdq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ID_BITS_DEF  = 32;

    localparam int MODE_W   = 3;
    localparam int IN_ID_W  = 32;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP        = 3'd2,
        MODE_CONTAINS   = 3'd3,
        MODE_REMOVE     = 3'd4,
        MODE_READ       = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_POS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_PUSH_FRONT,
        ACT_PUSH_BACK,
        ACT_POP,
        ACT_READ,
        ACT_FLAG,
        ACT_SCAN_FIRST,
        ACT_SCAN_STEP,
        ACT_MATCH_ONLY,
        ACT_MATCH_SHIFT,
        ACT_MATCH_LAST,
        ACT_SHIFT_STEP,
        ACT_SHIFT_LAST,
        ACT_OUT
    } act_t;

    typedef struct packed {
        act_t    act;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              empty;
        logic              pos_ok;
        logic              match;
        logic              more;
        logic              shift_more;
    } dp_stat_t;

endpackage

### rtl/bdq_chan_if.sv
// Request and response channel interfaces for the bounded deque.
interface bdq_req_if;
    logic                          valid;
    logic                          ready;
    logic [bdq_pkg::MODE_W-1:0]    mode;
    logic [bdq_pkg::IN_ID_W-1:0]   item_id;
    logic [bdq_pkg::POS_W-1:0]     position;

    modport source (output valid, mode, item_id, position, input ready);
    modport sink   (input valid, mode, item_id, position, output ready);
endinterface

interface bdq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bdq_pkg::VALUE_W-1:0]   value;
    logic                          found;
    logic [bdq_pkg::STATUS_W-1:0]  status;
    logic [bdq_pkg::COUNT_W-1:0]   count;

    modport source (output valid, value, found, status, count, input ready);
    modport sink   (input valid, value, found, status, count, output ready);
endinterface

### rtl/bdq_ctrl.sv
// Controller state machine: sequences each operation and owns the handshakes.
module bdq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  bdq_pkg::dp_stat_t stat,
    output bdq_pkg::dp_cmd_t  cmd
);

    bdq_pkg::state_t state_reg;
    bdq_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == bdq_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.act        = bdq_pkg::ACT_NONE;
        cmd.status     = bdq_pkg::ST_OK;
        out_valid_next = rsp_ready ? 1'b0 : out_valid_reg;

        case (state_reg)
            bdq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.act    = bdq_pkg::ACT_LOAD;
                    state_next = bdq_pkg::S_ISSUE;
                end
            end

            bdq_pkg::S_ISSUE:
            begin
                state_next = bdq_pkg::S_FINISH;
                case (stat.mode)
                    bdq_pkg::MODE_PUSH_FRONT:
                    begin
                        if (stat.full)
                        begin
                            cmd.act    = bdq_pkg::ACT_FLAG;
                            cmd.status = bdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.act = bdq_pkg::ACT_PUSH_FRONT;
                        end
                    end
                    bdq_pkg::MODE_PUSH_BACK:
                    begin
                        if (stat.full)
                        begin
                            cmd.act    = bdq_pkg::ACT_FLAG;
                            cmd.status = bdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.act = bdq_pkg::ACT_PUSH_BACK;
                        end
                    end
                    bdq_pkg::MODE_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.act    = bdq_pkg::ACT_FLAG;
                            cmd.status = bdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.act = bdq_pkg::ACT_POP;
                        end
                    end
                    bdq_pkg::MODE_READ:
                    begin
                        if (stat.pos_ok)
                        begin
                            cmd.act = bdq_pkg::ACT_READ;
                        end
                        else
                        begin
                            cmd.act    = bdq_pkg::ACT_FLAG;
                            cmd.status = bdq_pkg::ST_BAD_POS;
                        end
                    end
                    bdq_pkg::MODE_CONTAINS, bdq_pkg::MODE_REMOVE:
                    begin
                        if (!stat.empty)
                        begin
                            cmd.act    = bdq_pkg::ACT_SCAN_FIRST;
                            state_next = bdq_pkg::S_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.act = bdq_pkg::ACT_NONE;
                    end
                endcase
            end

            bdq_pkg::S_SCAN:
            begin
                if (stat.match)
                begin
                    if (stat.mode != bdq_pkg::MODE_REMOVE)
                    begin
                        cmd.act    = bdq_pkg::ACT_MATCH_ONLY;
                        state_next = bdq_pkg::S_FINISH;
                    end
                    else if (stat.more)
                    begin
                        cmd.act    = bdq_pkg::ACT_MATCH_SHIFT;
                        state_next = bdq_pkg::S_SHIFT;
                    end
                    else
                    begin
                        cmd.act    = bdq_pkg::ACT_MATCH_LAST;
                        state_next = bdq_pkg::S_FINISH;
                    end
                end
                else if (stat.more)
                begin
                    cmd.act = bdq_pkg::ACT_SCAN_STEP;
                end
                else
                begin
                    state_next = bdq_pkg::S_FINISH;
                end
            end

            bdq_pkg::S_SHIFT:
            begin
                if (stat.shift_more)
                begin
                    cmd.act = bdq_pkg::ACT_SHIFT_STEP;
                end
                else
                begin
                    cmd.act    = bdq_pkg::ACT_SHIFT_LAST;
                    state_next = bdq_pkg::S_FINISH;
                end
            end

            bdq_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.act        = bdq_pkg::ACT_OUT;
                    out_valid_next = 1'b1;
                    state_next     = bdq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bdq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/bdq_datapath.sv
// Datapath: circular entry store, pointers, scan index and result register.
module bdq_datapath
#(
    parameter int CAPACITY = bdq_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = bdq_pkg::ID_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  bdq_pkg::dp_cmd_t               cmd,
    output bdq_pkg::dp_stat_t              stat,
    input  logic [bdq_pkg::MODE_W-1:0]     req_mode,
    input  logic [bdq_pkg::IN_ID_W-1:0]    req_item_id,
    input  logic [bdq_pkg::POS_W-1:0]      req_position,
    output logic [bdq_pkg::VALUE_W-1:0]    rsp_value,
    output logic                           rsp_found,
    output logic [bdq_pkg::STATUS_W-1:0]   rsp_status,
    output logic [bdq_pkg::COUNT_W-1:0]    rsp_count
);

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(CAPACITY))
        begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

    logic [ID_BITS-1:0]          mem [CAPACITY];

    logic [PTR_W-1:0]            front_reg;
    logic [PTR_W-1:0]            front_next;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;

    logic [bdq_pkg::MODE_W-1:0]  mode_reg;
    logic [ID_BITS-1:0]          id_reg;
    logic [bdq_pkg::POS_W-1:0]   pos_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic                        found_reg;
    bdq_pkg::status_t            status_reg;
    logic                        take_rd_reg;
    logic [ID_BITS-1:0]          rd_data_reg;

    logic [bdq_pkg::VALUE_W-1:0] out_value_reg;
    logic                        out_found_reg;
    bdq_pkg::status_t            out_status_reg;
    logic [bdq_pkg::COUNT_W-1:0] out_count_reg;

    logic                        rd_en;
    logic [PTR_W-1:0]            rd_addr;
    logic                        wr_en;
    logic [PTR_W-1:0]            wr_addr;
    logic [ID_BITS-1:0]          wr_data;
    logic [PTR_W-1:0]            front_dec;
    logic [63:0]                 id_wide;
    logic [63:0]                 rd_wide;
    logic [63:0]                 count_wide;
    logic [CNT_W:0]              idx_inc;

    assign id_wide    = 64'(req_item_id);
    assign rd_wide    = 64'(rd_data_reg);
    assign count_wide = 64'(count_reg);
    assign front_dec  = (front_reg == '0) ? PTR_W'(CAPACITY - 1) : front_reg - 1'b1;
    assign idx_inc    = (CNT_W+1)'(idx_reg) + 1'b1;

    assign stat.mode       = mode_reg;
    assign stat.full       = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty      = (count_reg == '0);
    assign stat.pos_ok     = (32'(pos_reg) < 32'(count_reg));
    assign stat.match      = (rd_data_reg == id_reg);
    assign stat.more       = (idx_reg < count_reg);
    assign stat.shift_more = (idx_inc < (CNT_W+1)'(count_reg));

    always_comb
    begin
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        wr_en      = 1'b0;
        wr_addr    = front_dec;
        wr_data    = id_reg;
        front_next = front_reg;
        count_next = count_reg;
        case (cmd.act)
            bdq_pkg::ACT_PUSH_FRONT:
            begin
                wr_en      = 1'b1;
                front_next = front_dec;
                count_next = count_reg + 1'b1;
            end
            bdq_pkg::ACT_PUSH_BACK:
            begin
                wr_en      = 1'b1;
                wr_addr    = phys(front_reg, count_reg);
                count_next = count_reg + 1'b1;
            end
            bdq_pkg::ACT_POP:
            begin
                rd_en      = 1'b1;
                front_next = phys(front_reg, CNT_W'(1));
                count_next = count_reg - 1'b1;
            end
            bdq_pkg::ACT_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = phys(front_reg, CNT_W'(pos_reg));
            end
            bdq_pkg::ACT_SCAN_FIRST:
            begin
                rd_en = 1'b1;
            end
            bdq_pkg::ACT_SCAN_STEP, bdq_pkg::ACT_MATCH_SHIFT:
            begin
                rd_en   = 1'b1;
                rd_addr = phys(front_reg, idx_reg);
            end
            bdq_pkg::ACT_MATCH_LAST:
            begin
                count_next = count_reg - 1'b1;
            end
            bdq_pkg::ACT_SHIFT_STEP:
            begin
                rd_en   = 1'b1;
                rd_addr = phys(front_reg, idx_inc[CNT_W-1:0]);
                wr_en   = 1'b1;
                wr_addr = phys(front_reg, idx_reg - 1'b1);
                wr_data = rd_data_reg;
            end
            bdq_pkg::ACT_SHIFT_LAST:
            begin
                wr_en      = 1'b1;
                wr_addr    = phys(front_reg, idx_reg - 1'b1);
                wr_data    = rd_data_reg;
                count_next = count_reg - 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.act)
            bdq_pkg::ACT_LOAD:
            begin
                mode_reg    <= req_mode;
                id_reg      <= id_wide[ID_BITS-1:0];
                pos_reg     <= req_position;
                found_reg   <= 1'b0;
                status_reg  <= bdq_pkg::ST_OK;
                take_rd_reg <= 1'b0;
            end
            bdq_pkg::ACT_POP, bdq_pkg::ACT_READ:
            begin
                take_rd_reg <= 1'b1;
            end
            bdq_pkg::ACT_FLAG:
            begin
                status_reg <= cmd.status;
            end
            bdq_pkg::ACT_SCAN_FIRST:
            begin
                idx_reg <= CNT_W'(1);
            end
            bdq_pkg::ACT_SCAN_STEP, bdq_pkg::ACT_SHIFT_STEP:
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            bdq_pkg::ACT_MATCH_ONLY, bdq_pkg::ACT_MATCH_SHIFT, bdq_pkg::ACT_MATCH_LAST:
            begin
                found_reg <= 1'b1;
            end
            bdq_pkg::ACT_OUT:
            begin
                out_value_reg  <= take_rd_reg ? rd_wide[bdq_pkg::VALUE_W-1:0] : '0;
                out_found_reg  <= found_reg;
                out_status_reg <= status_reg;
                out_count_reg  <= count_wide[bdq_pkg::COUNT_W-1:0];
            end
            default:
            begin
                found_reg <= found_reg;
            end
        endcase
    end

    assign rsp_value  = out_value_reg;
    assign rsp_found  = out_found_reg;
    assign rsp_status = out_status_reg;
    assign rsp_count  = out_count_reg;

endmodule

### rtl/bounded_deque_with_search_remove.sv
// Push, pop, read and unused modes pass from acceptance through the issue and finish states.
// Contains and remove walk the store one entry per cycle through its single read port;
// a miss reads every entry, and a remove shifts each later entry one place toward the front.
// One item in flight; the next is accepted the cycle after the result enters the output register.
// Reset (rst_n, async, active low) empties the list; entry contents stay undefined.
// A waiting result does not block acceptance; the next item then holds in the finish state.
module bounded_deque_with_search_remove
#(
    parameter int CAPACITY = bdq_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = bdq_pkg::ID_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp
);

    `include "bounded_deque_with_search_remove_assert.svh"

    bdq_pkg::dp_cmd_t  cmd;
    bdq_pkg::dp_stat_t stat;

    bdq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bdq_datapath
    #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_mode     (req.mode),
        .req_item_id  (req.item_id),
        .req_position (req.position),
        .rsp_value    (rsp.value),
        .rsp_found    (rsp.found),
        .rsp_status   (rsp.status),
        .rsp_count    (rsp.count)
    );

    `BDQ_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "item accepted while busy")
    `BDQ_ASSERT_NOW(a_found_ok, rsp.valid && rsp.found, rsp.status == bdq_pkg::ST_OK, "found with error status")
    `BDQ_ASSERT_NOW(a_fail_zero, rsp.valid && rsp.status != bdq_pkg::ST_OK, rsp.value == '0, "value on failure")
    `BDQ_ASSERT_NOW(a_count_cap, rsp.valid, 32'(rsp.count) <= 32'(CAPACITY), "count beyond capacity")

endmodule
